FILE: rtl/schc_pkg.sv
// ----------------------------------------------------------------------------
// schc_pkg: shared types and constants for the skin colour histogram classifier
// Item structs, the sequencer state type and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package schc_pkg;

	localparam int unsigned BIN_BITS_DEF = 6;
	localparam int unsigned CH_W         = 8;
	localparam int unsigned CNT_W        = 16;
	localparam int unsigned TOT_W        = 32;
	localparam int unsigned PROB_W       = 8;

	localparam logic CMD_TRAIN    = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	typedef struct packed {
		logic              command;
		logic [CH_W-1:0]   blue;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   red;
		logic              is_skin;
	} schc_in_t;

	typedef struct packed {
		logic [PROB_W-1:0] probability;
		logic [TOT_W-1:0]  trained_total;
		logic              status;
	} schc_out_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_DIV,
		ST_DONE
	} schc_state_t;

endpackage

`default_nettype wire

FILE: rtl/schc_ram.sv
// ----------------------------------------------------------------------------
// schc_ram: generic single-port RAM
// One address per cycle, write or read, read data registered (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module schc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

FILE: rtl/skin_color_histogram_classifier.sv
// ----------------------------------------------------------------------------
// skin_color_histogram_classifier: colour histogram skin trainer and classifier
// Per-bin skin/total counts in one RAM, global totals, serial 8-bit divider.
// ----------------------------------------------------------------------------
// Usage:
//   pixel channel (pixel_valid / pixel_stall / pixel) takes one item: a train
//   command updates the histogram bin of the top BIN_BITS of blue, green and
//   red, a classify command returns round(255*skin/total) for that bin.
//   result channel (result_valid / result_stall / result) gives one item per
//   pixel item: probability, trained total and not-ready status.
//   One item is in work at a time. A train item, or a classify item that
//   needs no division, passes through READ, CALC and DONE; a classify item
//   that divides also runs DIV, the restoring divider (one quotient bit per
//   cycle), between CALC and DONE. The next item can be accepted in IDLE, in the
//   cycle after the result is loaded. The result sits in an output register,
//   so a stalled receiver does not hold off the next item; that item then
//   waits in DONE until its result can be loaded into the output register.
//   After reset the histogram RAM is swept clear, one bin per cycle, over all
//   2^(3*BIN_BITS) bins (262144 at the default); pixel_stall is high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module skin_color_histogram_classifier #(
	parameter int unsigned BIN_BITS = schc_pkg::BIN_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pixel_valid,
	output logic                   pixel_stall,
	input  wire schc_pkg::schc_in_t  pixel,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output schc_pkg::schc_out_t    result
);

	import schc_pkg::*;

	localparam int unsigned ADDR_W  = 3 * BIN_BITS;
	localparam int unsigned DEPTH   = 1 << ADDR_W;
	localparam int unsigned WORD_W  = 2 * CNT_W;
	// 510*s + t with s <= t < 2^16 stays below 2^25
	localparam int unsigned NUM_W   = CNT_W + 9;
	localparam int unsigned STEP_W  = $clog2(PROB_W);

	schc_state_t state_q, state_d;

	schc_in_t              item_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [ADDR_W-1:0]     bin_idx;
	logic [STEP_W-1:0]     step_q;
	logic [NUM_W-1:0]      rem_q;
	logic [NUM_W-1:0]      div_q;
	logic [PROB_W-1:0]     quot_q;
	logic [TOT_W-1:0]      skin_total_q;
	logic [TOT_W-1:0]      non_skin_total_q;
	logic                  out_valid_q;
	schc_out_t             out_q;

	logic [ADDR_W-1:0]     ram_addr;
	logic                  ram_we;
	logic [WORD_W-1:0]     ram_wdata;
	logic [WORD_W-1:0]     ram_rdata;

	logic [CNT_W-1:0]      rd_skin;
	logic [CNT_W-1:0]      rd_total;
	logic [CNT_W-1:0]      new_skin;
	logic [CNT_W-1:0]      new_total;
	logic                  not_ready;
	logic                  do_divide;
	logic                  out_free;
	logic [TOT_W:0]        total_sum;
	logic [NUM_W-1:0]      numerator;

	assign bin_idx = {item_q.blue[CH_W-1 -: BIN_BITS],
	                  item_q.green[CH_W-1 -: BIN_BITS],
	                  item_q.red[CH_W-1 -: BIN_BITS]};

	assign rd_skin   = ram_rdata[WORD_W-1 -: CNT_W];
	assign rd_total  = ram_rdata[CNT_W-1:0];
	assign new_skin  = (item_q.is_skin && rd_skin != '1) ? rd_skin + 1'b1 : rd_skin;
	assign new_total = (rd_total != '1) ? rd_total + 1'b1 : rd_total;

	assign not_ready = (skin_total_q == '0) || (non_skin_total_q == '0);
	assign do_divide = (item_q.command == CMD_CLASSIFY) && !not_ready && (rd_total != '0);
	assign out_free  = !out_valid_q || !result_stall;
	assign total_sum = {1'b0, skin_total_q} + {1'b0, non_skin_total_q};
	assign numerator = {rd_skin, 9'b0} - {{(NUM_W-CNT_W-1){1'b0}}, rd_skin, 1'b0}
	                   + {{(NUM_W-CNT_W){1'b0}}, rd_total};

	schc_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
			ST_IDLE:  if (pixel_valid) state_d = ST_READ;
			ST_READ:  state_d = ST_CALC;
			ST_CALC:  state_d = do_divide ? ST_DIV : ST_DONE;
			ST_DIV:   if (step_q == STEP_W'(PROB_W - 1)) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// outputs to RAM and handshake
	always_comb begin
		pixel_stall = 1'b1;
		ram_addr    = bin_idx;
		ram_we      = 1'b0;
		ram_wdata   = {new_skin, new_total};
		case (state_q)
			ST_CLEAR: begin
				ram_addr  = clr_q;
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			ST_IDLE: begin
				pixel_stall = 1'b0;
			end
			ST_CALC: begin
				ram_we = (item_q.command == CMD_TRAIN);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			clr_q            <= '0;
			skin_total_q     <= '0;
			non_skin_total_q <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_CALC && item_q.command == CMD_TRAIN) begin
				if (item_q.is_skin) begin
					if (skin_total_q != '1) skin_total_q <= skin_total_q + 1'b1;
				end else begin
					if (non_skin_total_q != '1) non_skin_total_q <= non_skin_total_q + 1'b1;
				end
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath: item capture, serial restoring divider, result register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pixel_valid) begin
			item_q <= pixel;
		end
		case (state_q)
			ST_CALC: begin
				quot_q <= '0;
				step_q <= '0;
				rem_q  <= numerator;
				div_q  <= {{(NUM_W-CNT_W-PROB_W){1'b0}}, rd_total, {PROB_W{1'b0}}};
			end
			ST_DIV: begin
				if (rem_q >= div_q) begin
					rem_q  <= rem_q - div_q;
					quot_q <= {quot_q[PROB_W-2:0], 1'b1};
				end else begin
					quot_q <= {quot_q[PROB_W-2:0], 1'b0};
				end
				div_q  <= div_q >> 1;
				step_q <= step_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			// quotient only stands when the divider ran for this item
			out_q.probability   <= (item_q.command == CMD_CLASSIFY && !not_ready
			                        && div_q != '0) ? quot_q : '0;
			out_q.trained_total <= total_sum[TOT_W] ? '1 : total_sum[TOT_W-1:0];
			out_q.status        <= not_ready;
		end
		if (state_q == ST_READ) begin
			// mark the divider idle until CALC decides otherwise
			div_q <= '0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

FILE: tb/skin_color_histogram_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// skin_color_histogram_classifier_tb: self-checking bench for the skin classifier
// Drives train and classify pixels and keeps its own copy of the bins and totals.
// Every result is checked against that copy, in order. The run covers the
// not-ready start, empty bins and bins shared by neighbouring colours.
// The rest is random pixels, most of them on a few busy bins, under several
// idling patterns and one long receiver hold-off.
// ----------------------------------------------------------------------------

module skin_color_histogram_classifier_tb;

	import schc_pkg::*;

	localparam int unsigned BIN_BITS    = BIN_BITS_DEF;
	localparam int unsigned BIN_COUNT   = 1 << (3 * BIN_BITS);
	localparam int unsigned HOT_COUNT   = 8;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PHASE_ITEMS = 200;

	class skin_hist_scoreboard;
		bit [CNT_W-1:0] skin_cnt [BIN_COUNT];
		bit [CNT_W-1:0] total_cnt [BIN_COUNT];
		bit [TOT_W-1:0] skin_total;
		bit [TOT_W-1:0] other_total;
		schc_out_t      pending[$];
		int unsigned    mismatches;
		int unsigned    compared;
		int unsigned    trains;
		int unsigned    classifies;
		int unsigned    nonzero_probs;

		function int unsigned bin_of(schc_in_t px);
			return 32'({px.blue[CH_W-1 -: BIN_BITS], px.green[CH_W-1 -: BIN_BITS],
				px.red[CH_W-1 -: BIN_BITS]});
		endfunction

		// work out the result of one accepted pixel and queue it
		function void note_pixel(schc_in_t px);
			int unsigned     idx;
			schc_out_t       want;
			bit [TOT_W:0]    sum;
			longint unsigned s;
			longint unsigned t;
			longint unsigned q;
			idx = bin_of(px);
			want = '0;
			if (px.command == CMD_TRAIN) begin
				trains++;
				if (px.is_skin) begin
					if (skin_total != '1)
						skin_total++;
					if (skin_cnt[idx] != '1)
						skin_cnt[idx]++;
				end else begin
					if (other_total != '1)
						other_total++;
				end
				if (total_cnt[idx] != '1)
					total_cnt[idx]++;
			end else begin
				classifies++;
				if (skin_total != 0 && other_total != 0 && total_cnt[idx] != 0) begin
					s = skin_cnt[idx];
					t = total_cnt[idx];
					q = (510 * s + t) / (2 * t);
					if (q > 255)
						q = 255;
					want.probability = q[PROB_W-1:0];
					if (q != 0)
						nonzero_probs++;
				end
			end
			sum = {1'b0, skin_total} + {1'b0, other_total};
			want.trained_total = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
			want.status = (skin_total == 0 || other_total == 0);
			pending.insert(pending.size(), want);
		endfunction

		function void check_result(schc_out_t got);
			schc_out_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing outstanding: prob %0d total %0d status %0d",
						$realtime, got.probability, got.trained_total, got.status);
				return;
			end
			want = pending.pop_front();
			compared++;
			if (got.probability !== want.probability || got.trained_total !== want.trained_total
					|| got.status !== want.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result %0d: prob %0d/%0d total %0d/%0d status %0d/%0d (exp/act)",
						$realtime, compared, want.probability, got.probability,
						want.trained_total, got.trained_total, want.status, got.status);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n       = 1'b0;
	logic      pixel_valid  = 1'b0;
	logic      pixel_stall;
	schc_in_t  pixel        = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	schc_out_t result;

	skin_hist_scoreboard scores;
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_req  = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	logic [3*BIN_BITS-1:0] hot_bins [HOT_COUNT];

	skin_color_histogram_classifier #(
		.BIN_BITS(BIN_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// time-out: long enough for the clearing sweep of all 262144 bins and every item
	initial begin
		#50_000_000;
		$display("skin_color_histogram_classifier_tb NOT OK");
		$finish;
	end

	// result side: check, then pick the stall for the next edge
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			scores.check_result(result);
		if (hold_req != hold_seen) begin
			hold_left = HOLD_CYCLES;
			hold_seen = hold_req;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_pixel(input schc_in_t px);
		while ($urandom_range(99) < gap_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (pixel_stall)
			@(posedge clk);
		scores.note_pixel(px);
	endtask

	task automatic send(input logic cmd, input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r, input logic skin);
		schc_in_t px;
		px.command = cmd;
		px.blue = b;
		px.green = g;
		px.red = r;
		px.is_skin = skin;
		send_pixel(px);
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (scores.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// mostly busy bins so that counts build up; the rest anywhere in colour space
	function automatic schc_in_t random_pixel();
		schc_in_t    px;
		int unsigned k;
		px.command = ($urandom_range(99) < 50) ? CMD_CLASSIFY : CMD_TRAIN;
		px.blue = CH_W'($urandom_range(255));
		px.green = CH_W'($urandom_range(255));
		px.red = CH_W'($urandom_range(255));
		px.is_skin = 1'($urandom_range(1));
		if ($urandom_range(99) < 80) begin
			k = $urandom_range(HOT_COUNT - 1);
			{px.blue[CH_W-1 -: BIN_BITS], px.green[CH_W-1 -: BIN_BITS],
				px.red[CH_W-1 -: BIN_BITS]} = hot_bins[k];
			// low-numbered bins lean non-skin, high-numbered ones skin
			px.is_skin = ($urandom_range(HOT_COUNT - 2) < k);
		end
		return px;
	endfunction

	initial begin
		scores = new;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// not ready, empty bins, bin sharing and a few ratios
		send(CMD_CLASSIFY, 8'h00, 8'h00, 8'h00, 1'b0);
		send(CMD_CLASSIFY, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send(CMD_TRAIN,    8'hFF, 8'hFF, 8'hFF, 1'b1);
		send(CMD_CLASSIFY, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send(CMD_TRAIN,    8'h00, 8'h00, 8'h00, 1'b0);
		send(CMD_CLASSIFY, 8'hFF, 8'hFE, 8'hFC, 1'b0);
		send(CMD_CLASSIFY, 8'h00, 8'h03, 8'h01, 1'b1);
		send(CMD_TRAIN,    8'h80, 8'h40, 8'h20, 1'b1);
		send(CMD_TRAIN,    8'h80, 8'h40, 8'h20, 1'b0);
		send(CMD_TRAIN,    8'h83, 8'h43, 8'h23, 1'b0);
		send(CMD_CLASSIFY, 8'h81, 8'h42, 8'h23, 1'b0);
		send(CMD_CLASSIFY, 8'h7F, 8'h40, 8'h20, 1'b0);
		send(CMD_TRAIN,    8'h10, 8'hF0, 8'h0F, 1'b1);
		send(CMD_TRAIN,    8'h10, 8'hF0, 8'h0F, 1'b0);
		send(CMD_CLASSIFY, 8'h13, 8'hF3, 8'h0C, 1'b1);
		send(CMD_TRAIN,    8'hAA, 8'h55, 8'hAA, 1'b1);
		send(CMD_TRAIN,    8'hAA, 8'h55, 8'hAA, 1'b1);
		send(CMD_TRAIN,    8'hAA, 8'h55, 8'hAA, 1'b0);
		send(CMD_CLASSIFY, 8'hA8, 8'h57, 8'hA9, 1'b0);
		send(CMD_CLASSIFY, 8'h55, 8'hAA, 8'h55, 1'b1);
		send(CMD_CLASSIFY, 8'h00, 8'h00, 8'h00, 1'b1);
		drain();

		for (int unsigned k = 0; k < HOT_COUNT; k++)
			hot_bins[k] = (3*BIN_BITS)'($urandom);
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
					hold_req++;
				end
				1: begin
					gap_pct = 62;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 62;
				end
				default: begin
					gap_pct = 18;
					stall_pct = 18;
				end
			endcase
			for (int unsigned i = 0; i < PHASE_ITEMS; i++)
				send_pixel(random_pixel());
			drain();
		end

		stall_pct = 0;
		$display("Sent %0d train and %0d classify pixels, %0d results compared, %0d of them nonzero.",
			scores.trains, scores.classifies, scores.compared, scores.nonzero_probs);
		$display("Covered not-ready start, empty bins, shared bins and a long output hold-off.");
		if (scores.mismatches == 0 && scores.pending.size() == 0) begin
			$display("skin_color_histogram_classifier_tb OK");
		end else begin
			$display("skin_color_histogram_classifier_tb NOT OK");
		end
		$finish;
	end

endmodule
